>>> hw/rtl/saf_pkg.sv
// ============================================================================
// saf_pkg
// shared types and constants for the shifter alu with flags block
// ============================================================================
package saf_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        CMD_WIDE_DP   = 3'd0,
        CMD_SHIFT_IMM = 3'd1,
        CMD_ADDSUB3   = 3'd2,
        CMD_IMM8      = 3'd3,
        CMD_ALU       = 3'd4,
        CMD_HIREG     = 3'd5,
        CMD_SPPC_ADD  = 3'd6,
        CMD_SP_ADJ    = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef enum logic [3:0] {
        ALU_AND = 4'd0,
        ALU_EOR = 4'd1,
        ALU_SUB = 4'd2,
        ALU_RSB = 4'd3,
        ALU_ADD = 4'd4,
        ALU_ADC = 4'd5,
        ALU_SBC = 4'd6,
        ALU_RSC = 4'd7,
        ALU_TST = 4'd8,
        ALU_TEQ = 4'd9,
        ALU_CMP = 4'd10,
        ALU_CMN = 4'd11,
        ALU_ORR = 4'd12,
        ALU_MOV = 4'd13,
        ALU_BIC = 4'd14,
        ALU_MVN = 4'd15
    } t_alu_op;

    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [3:0] REG_SP = 4'd13;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        logic [3:0]        dest;
        logic              we;
        logic              rst;
        logic              uns;
        logic              commit;
        t_flags            flags;
    } t_exec_out;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [WORD_W-1:0] instr;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
        logic [WORD_W-1:0] op_s;
    } t_exec_in;

endpackage

>>> hw/rtl/saf_shifter.sv
// ============================================================================
// saf_shifter
// barrel shifter: lsl, lsr, asr, ror with carry-out, amounts up to 255
// ============================================================================
module saf_shifter (
    input  logic [31:0]     i_x,
    input  saf_pkg::t_shift i_typ,
    input  logic [7:0]      i_amt,
    input  logic            i_cin,
    output logic [31:0]     o_r,
    output logic            o_cout
);
    import saf_pkg::*;

    logic [32:0] lsl_w;
    logic [32:0] lsr_w;
    logic [32:0] asr_w;
    logic [63:0] ror_w;
    logic        big;
    logic        is32;
    logic        sign;

    assign sign  = i_x[31];
    assign lsl_w = {1'b0, i_x} << i_amt[4:0];
    assign lsr_w = {i_x, 1'b0} >> i_amt[4:0];
    assign asr_w = 33'($signed({i_x, 1'b0}) >>> i_amt[4:0]);
    assign ror_w = {i_x, i_x} >> i_amt[4:0];
    assign big   = (i_amt[7:5] != 3'd0);
    assign is32  = (i_amt == 8'd32);

    always_comb begin
        o_r    = i_x;
        o_cout = i_cin;
        if (i_amt != 8'd0) begin
            unique case (i_typ)
                SH_LSL: begin
                    if (!big) begin
                        o_r    = lsl_w[31:0];
                        o_cout = lsl_w[32];
                    end else begin
                        o_r    = '0;
                        o_cout = is32 ? i_x[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (!big) begin
                        o_r    = lsr_w[32:1];
                        o_cout = lsr_w[0];
                    end else begin
                        o_r    = '0;
                        o_cout = is32 ? sign : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (!big) begin
                        o_r    = asr_w[32:1];
                        o_cout = asr_w[0];
                    end else begin
                        o_r    = {32{sign}};
                        o_cout = sign;
                    end
                end
                SH_ROR: begin
                    o_r    = ror_w[31:0];
                    o_cout = ror_w[31];
                end
                default: begin
                    o_r    = i_x;
                    o_cout = i_cin;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/saf_exec.sv
// ============================================================================
// saf_exec
// instruction decode, operand shift and alu for one instruction
// ============================================================================
module saf_exec (
    input  saf_pkg::t_exec_in  i_in,
    input  saf_pkg::t_flags    i_flags,
    output saf_pkg::t_exec_out o_out
);
    import saf_pkg::*;

    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    t_cmd        cmd;

    // shifter controls
    logic [31:0] sh_x;
    t_shift      sh_typ;
    logic [7:0]  sh_amt;
    logic [31:0] sh_r;
    logic        sh_c;

    // alu controls
    t_alu_op     alu_op;
    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_sc;
    logic [31:0] alu_r;
    logic        alu_co;
    logic        alu_vo;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        acin;
    logic        arith;
    logic [32:0] sum;

    logic        use_shift;
    logic        kill;
    logic        wide_uns;
    logic        rrx;
    logic [4:0]  amt5;
    logic [31:0] res;

    assign ins = i_in.instr;
    assign a   = i_in.op_a;
    assign b   = i_in.op_b;
    assign cmd = t_cmd'(i_in.cmd);

    assign wide_uns = (!ins[25] && ins[7:4] == 4'd9)
                    || ((ins & 32'h0FFF_FFD0) == 32'h012F_FF10);
    assign amt5     = (cmd == CMD_WIDE_DP) ? ins[11:7] : ins[10:6];
    assign rrx      = !ins[25] && !ins[4] && ins[6:5] == 2'd3 && ins[11:7] == 5'd0;

    // shifter input select
    always_comb begin
        sh_x   = b;
        sh_typ = SH_LSL;
        sh_amt = 8'd0;
        unique case (cmd)
            CMD_WIDE_DP: begin
                if (ins[25]) begin
                    sh_x   = {24'd0, ins[7:0]};
                    sh_typ = SH_ROR;
                    sh_amt = {3'd0, ins[11:8], 1'b0};
                end else if (ins[4]) begin
                    sh_typ = t_shift'(ins[6:5]);
                    sh_amt = i_in.op_s[7:0];
                end else begin
                    sh_typ = t_shift'(ins[6:5]);
                    // zero amount on lsr and asr means 32
                    if (amt5 == 5'd0 && (ins[6:5] == 2'd1 || ins[6:5] == 2'd2)) begin
                        sh_amt = 8'd32;
                    end else begin
                        sh_amt = {3'd0, amt5};
                    end
                end
            end
            CMD_SHIFT_IMM: begin
                sh_typ = t_shift'(ins[12:11]);
                if (amt5 == 5'd0 && ins[12:11] != 2'd0) begin
                    sh_amt = 8'd32;
                end else begin
                    sh_amt = {3'd0, amt5};
                end
            end
            CMD_ALU: begin
                sh_x   = a;
                sh_amt = b[7:0];
                unique case (ins[9:6])
                    4'd2:    sh_typ = SH_LSL;
                    4'd3:    sh_typ = SH_LSR;
                    4'd4:    sh_typ = SH_ASR;
                    default: sh_typ = SH_ROR;
                endcase
            end
            default: begin
                sh_x   = b;
                sh_typ = SH_LSL;
                sh_amt = 8'd0;
            end
        endcase
    end

    saf_shifter u_shifter (
        .i_x    (sh_x),
        .i_typ  (sh_typ),
        .i_amt  (sh_amt),
        .i_cin  (i_flags.c),
        .o_r    (sh_r),
        .o_cout (sh_c)
    );

    // decode and alu operand select
    always_comb begin
        alu_op          = ALU_AND;
        alu_a           = a;
        alu_b           = b;
        alu_sc          = i_flags.c;
        use_shift       = 1'b0;
        kill            = 1'b0;
        o_out.dest      = 4'd0;
        o_out.we        = 1'b0;
        o_out.rst       = 1'b0;
        o_out.uns       = 1'b0;
        o_out.commit    = 1'b0;
        unique case (cmd)
            CMD_WIDE_DP: begin
                if (wide_uns) begin
                    kill      = 1'b1;
                    o_out.uns = 1'b1;
                end else begin
                    o_out.dest = ins[15:12];
                    alu_op     = t_alu_op'(ins[24:21]);
                    if (rrx) begin
                        alu_b  = {i_flags.c, b[31:1]};
                        alu_sc = b[0];
                    end else begin
                        alu_b  = sh_r;
                        alu_sc = sh_c;
                    end
                    o_out.commit = ins[20] && ins[15:12] != REG_PC;
                    // compare and test forms write nothing
                    if (ins[24:23] != 2'b10) begin
                        o_out.we  = 1'b1;
                        o_out.rst = ins[20] && ins[15:12] == REG_PC;
                    end
                end
            end
            CMD_SHIFT_IMM: begin
                if (ins[12:11] == 2'd3) begin
                    kill = 1'b1;
                end else begin
                    o_out.dest   = {1'b0, ins[2:0]};
                    use_shift    = 1'b1;
                    o_out.commit = 1'b1;
                    o_out.we     = 1'b1;
                end
            end
            CMD_ADDSUB3: begin
                o_out.dest   = {1'b0, ins[2:0]};
                alu_op       = ins[9] ? ALU_SUB : ALU_ADD;
                alu_b        = ins[10] ? {29'd0, ins[8:6]} : b;
                o_out.commit = 1'b1;
                o_out.we     = 1'b1;
            end
            CMD_IMM8: begin
                o_out.dest = {1'b0, ins[10:8]};
                alu_b      = {24'd0, ins[7:0]};
                unique case (ins[12:11])
                    2'd0:    alu_op = ALU_MOV;
                    2'd1:    alu_op = ALU_CMP;
                    2'd2:    alu_op = ALU_ADD;
                    default: alu_op = ALU_SUB;
                endcase
                o_out.commit = 1'b1;
                o_out.we     = (ins[12:11] != 2'd1);
            end
            CMD_ALU: begin
                o_out.dest = {1'b0, ins[2:0]};
                if (ins[9:6] == 4'd13) begin
                    // compact multiply
                    kill       = 1'b1;
                    o_out.uns  = 1'b1;
                    o_out.dest = 4'd0;
                end else begin
                    if (ins[9:6] == 4'd2 || ins[9:6] == 4'd3 || ins[9:6] == 4'd4
                        || ins[9:6] == 4'd7) begin
                        use_shift = 1'b1;
                    end else if (ins[9:6] == 4'd9) begin
                        // negate
                        alu_op = ALU_SUB;
                        alu_a  = '0;
                    end else begin
                        alu_op = t_alu_op'(ins[9:6]);
                    end
                    o_out.commit = 1'b1;
                    o_out.we     = !(ins[9:6] == 4'd8 || ins[9:6] == 4'd10
                                     || ins[9:6] == 4'd11);
                end
            end
            CMD_HIREG: begin
                if (ins[9:8] == 2'd3) begin
                    kill      = 1'b1;
                    o_out.uns = 1'b1;
                end else begin
                    o_out.dest = {ins[7], ins[2:0]};
                    unique case (ins[9:8])
                        2'd0:    alu_op = ALU_ADD;
                        2'd1:    alu_op = ALU_CMP;
                        default: alu_op = ALU_MOV;
                    endcase
                    o_out.we     = (ins[9:8] != 2'd1);
                    o_out.commit = (ins[9:8] == 2'd1) && ({ins[7], ins[2:0]} != REG_PC);
                end
            end
            CMD_SPPC_ADD: begin
                o_out.dest = {1'b0, ins[10:8]};
                alu_op     = ALU_ADD;
                alu_a      = ins[11] ? a : {a[31:2], 2'b00};
                alu_b      = {22'd0, ins[7:0], 2'b00};
                o_out.we   = 1'b1;
            end
            default: begin
                o_out.dest = REG_SP;
                alu_op     = ins[7] ? ALU_SUB : ALU_ADD;
                alu_b      = {23'd0, ins[6:0], 2'b00};
                o_out.we   = 1'b1;
            end
        endcase
    end

    // alu
    always_comb begin
        ax    = alu_a;
        ay    = alu_b;
        acin  = 1'b0;
        arith = 1'b1;
        alu_r = '0;
        unique case (alu_op)
            ALU_SUB, ALU_CMP: begin ay = ~alu_b; acin = 1'b1; end
            ALU_RSB:          begin ax = alu_b; ay = ~alu_a; acin = 1'b1; end
            ALU_ADD, ALU_CMN: begin acin = 1'b0; end
            ALU_ADC:          begin acin = i_flags.c; end
            ALU_SBC:          begin ay = ~alu_b; acin = i_flags.c; end
            ALU_RSC:          begin ax = alu_b; ay = ~alu_a; acin = i_flags.c; end
            default:          begin arith = 1'b0; end
        endcase
        sum = {1'b0, ax} + {1'b0, ay} + {32'd0, acin};
        unique case (alu_op)
            ALU_AND, ALU_TST: alu_r = alu_a & alu_b;
            ALU_EOR, ALU_TEQ: alu_r = alu_a ^ alu_b;
            ALU_ORR:          alu_r = alu_a | alu_b;
            ALU_MOV:          alu_r = alu_b;
            ALU_BIC:          alu_r = alu_a & ~alu_b;
            ALU_MVN:          alu_r = ~alu_b;
            default:          alu_r = sum[31:0];
        endcase
        alu_co = arith ? sum[32] : alu_sc;
        alu_vo = arith ? ((~(ax[31] ^ ay[31])) & (ax[31] ^ sum[31])) : i_flags.v;
    end

    always_comb begin
        if (kill) begin
            res = '0;
        end else if (use_shift) begin
            res = sh_r;
        end else begin
            res = alu_r;
        end
        o_out.result  = res;
        o_out.flags.n = res[31];
        o_out.flags.z = (res == 32'd0);
        o_out.flags.c = use_shift ? sh_c : alu_co;
        o_out.flags.v = use_shift ? i_flags.v : alu_vo;
    end

endmodule

>>> hw/rtl/shifter_alu_with_flags_core.sv
// ============================================================================
// shifter_alu_with_flags_core
// execute stage: barrel shifter and sixteen-opcode alu with nzcv flags
// ============================================================================
// One instruction (wide data-processing or a compact form, with its register
// values) is taken per transfer on the slave stream and one result per
// instruction leaves on the master stream. Each instruction is held in the
// input register, where decode, shift and alu run in a single pass against
// the held nzcv flags, and is then written to the result register while the
// flags update at the same edge, so the next instruction already sees them:
// the block sustains one instruction per cycle while the master stream takes
// results; a result passes two register stages, input then result. The flag
// register loop through the shifter and the 32-bit adder sets the cycle
// time. Flags reset to zero. Multiply and branch-exchange forms return zeros
// with unsupported set and leave the flags alone.
module shifter_alu_with_flags_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // cmd[2:0], instr[34:3], first_operand[66:35], second_operand[98:67],
    // shift_operand[130:99], zero[135:131]
    input  logic [135:0] i_s_axis_tdata,
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_value[31:0], dest_reg[35:32], write_enable[36],
    // restore_status[37], neg_flag[38], zero_flag[39], carry_flag[40],
    // overflow_flag[41], unsupported[42], zero[47:43]
    output logic [47:0]  o_m_axis_tdata
);
    import saf_pkg::*;

    // input register
    logic      r_in_valid;
    t_exec_in  r_in;
    // result register and flag state
    logic      r_out_valid;
    t_exec_out r_out;
    t_flags    r_flags;

    t_exec_out exec_out;
    t_exec_out n_out;
    t_flags    n_flags;
    logic      s_xfer;
    logic      advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    saf_exec u_exec (
        .i_in    (r_in),
        .i_flags (r_flags),
        .o_out   (exec_out)
    );

    // flags after the instruction: new candidates only when it commits
    assign n_flags = exec_out.commit ? exec_out.flags : r_flags;

    // result word carries the flags as they stand after the instruction
    always_comb begin
        n_out       = exec_out;
        n_out.flags = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in.cmd   <= i_s_axis_tdata[2:0];
            r_in.instr <= i_s_axis_tdata[34:3];
            r_in.op_a  <= i_s_axis_tdata[66:35];
            r_in.op_b  <= i_s_axis_tdata[98:67];
            r_in.op_s  <= i_s_axis_tdata[130:99];
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.uns, r_out.flags.v, r_out.flags.c,
                              r_out.flags.z, r_out.flags.n, r_out.rst,
                              r_out.we, r_out.dest, r_out.result};

`ifndef ASSERT_OFF
    // flag state only moves when an instruction retires into the result stage
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_flags))
        else $error("flags changed without a retiring instruction");

    // a waiting result always carries the current flag state
    a_out_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flags == r_flags))
        else $error("result flags differ from flag state");

    // unsupported forms never write
    a_uns_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.uns) |-> (!r_out.we && !r_out.rst))
        else $error("unsupported instruction with a write");

    // a held instruction is not lost while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held instruction dropped");
`endif

endmodule

>>> verif/shifter_alu_with_flags_core_checker.sv
// ============================================================================
// shifter_alu_with_flags_core_checker
// watches both streams, predicts each result with its own nzcv copy, compares
// ============================================================================
module shifter_alu_with_flags_core_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [135:0] i_s_axis_tdata,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [47:0]  i_m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import saf_pkg::*;

    // lowest field last, matching the result tdata layout
    typedef struct packed {
        logic        uns;
        logic        v;
        logic        c;
        logic        z;
        logic        n;
        logic        rst;
        logic        we;
        logic [3:0]  dest;
        logic [31:0] result;
    } t_exec_result;

    t_exec_result exec_results_q[$];
    t_flags       held_flags;
    int           fail_count;
    int           pending;
    int           result_count;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    function automatic logic [31:0] barrel(input logic [31:0] x, input logic [1:0] kind,
                                           input int unsigned amt, inout logic cout);
        logic [31:0] r;
        logic [4:0]  k;
        r = x;
        if (amt == 0) return x;
        case (t_shift'(kind))
            SH_LSL: begin
                if (amt < 32) begin
                    cout = x[32-amt]; r = x << amt;
                end else begin
                    cout = (amt == 32) ? x[0] : 1'b0; r = '0;
                end
            end
            SH_LSR: begin
                if (amt < 32) begin
                    cout = x[amt-1]; r = x >> amt;
                end else begin
                    cout = (amt == 32) ? x[31] : 1'b0; r = '0;
                end
            end
            SH_ASR: begin
                if (amt < 32) begin
                    cout = x[amt-1]; r = $signed(x) >>> amt;
                end else begin
                    cout = x[31]; r = {32{x[31]}};
                end
            end
            default: begin
                k = amt[4:0];
                r = (k != 0) ? ((x >> k) | (x << (32 - k))) : x;
                cout = r[31];
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                              input logic cin, output logic co, output logic vo);
        logic [32:0] s;
        s  = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        co = s[32];
        vo = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
        return s[31:0];
    endfunction

    // alu op with candidate flags in f
    function automatic logic [31:0] alu_eval(input t_alu_op op, input logic [31:0] a,
                                             input logic [31:0] b, input logic sc,
                                             output t_flags f);
        logic [31:0] r;
        logic co, vo;
        co = sc;
        vo = held_flags.v;
        case (op)
            ALU_AND, ALU_TST: r = a & b;
            ALU_EOR, ALU_TEQ: r = a ^ b;
            ALU_SUB, ALU_CMP: r = add_carry(a, ~b, 1'b1, co, vo);
            ALU_RSB:          r = add_carry(b, ~a, 1'b1, co, vo);
            ALU_ADD, ALU_CMN: r = add_carry(a, b, 1'b0, co, vo);
            ALU_ADC:          r = add_carry(a, b, held_flags.c, co, vo);
            ALU_SBC:          r = add_carry(a, ~b, held_flags.c, co, vo);
            ALU_RSC:          r = add_carry(b, ~a, held_flags.c, co, vo);
            ALU_ORR:          r = a | b;
            ALU_MOV:          r = b;
            ALU_BIC:          r = a & ~b;
            default:          r = ~b;
        endcase
        f = '{n: r[31], z: (r == 0), c: co, v: vo};
        return r;
    endfunction

    function automatic t_exec_result execute(input logic [135:0] d);
        t_cmd        cmd;
        logic [31:0] ins, a, b, rs, sh, v, res;
        logic [3:0]  rd, op4;
        logic [1:0]  op2;
        logic        s, sc, we, rst, uns;
        int unsigned amt, rot;
        t_flags      f;
        t_alu_op     imm_map[4];
        t_alu_op     alu_map[16];
        t_exec_result o;
        imm_map = '{ALU_MOV, ALU_CMP, ALU_ADD, ALU_SUB};
        alu_map = '{ALU_AND, ALU_EOR, ALU_AND, ALU_AND, ALU_AND, ALU_ADC, ALU_SBC, ALU_AND,
                    ALU_TST, ALU_SUB, ALU_CMP, ALU_CMN, ALU_ORR, ALU_AND, ALU_BIC, ALU_MVN};
        cmd = t_cmd'(d[2:0]);
        ins = d[34:3]; a = d[66:35]; b = d[98:67]; rs = d[130:99];
        res = '0; rd = '0; we = 0; rst = 0; uns = 0;
        sc = held_flags.c;
        case (cmd)
            CMD_WIDE_DP: begin
                op4 = ins[24:21];
                s = ins[20];
                if ((!ins[25] && ins[7:4] == 4'b1001) ||
                    ((ins & 32'h0FFFFFD0) == 32'h012FFF10)) begin
                    uns = 1;
                end else begin
                    rd = ins[15:12];
                    if (ins[25]) begin
                        rot = ins[11:8] * 2;
                        v = {24'd0, ins[7:0]};
                        sh = (rot != 0) ? ((v >> rot) | (v << (32 - rot))) : v;
                        if (rot != 0) sc = sh[31];
                    end else if (ins[4]) begin
                        sh = barrel(b, ins[6:5], rs[7:0], sc);
                    end else begin
                        amt = ins[11:7];
                        if (ins[6:5] == SH_ROR && amt == 0) begin
                            // rrx through the held carry
                            sh = {held_flags.c, b[31:1]};
                            sc = b[0];
                        end else begin
                            if (amt == 0 && (ins[6:5] == SH_LSR || ins[6:5] == SH_ASR))
                                amt = 32;
                            sh = barrel(b, ins[6:5], amt, sc);
                        end
                    end
                    res = alu_eval(t_alu_op'(op4), a, sh, sc, f);
                    if (s && rd != REG_PC) held_flags = f;
                    if (!(op4 >= ALU_TST && op4 <= ALU_CMN)) begin
                        we = 1; rst = s && rd == REG_PC;
                    end
                end
            end
            CMD_SHIFT_IMM: begin
                op2 = ins[12:11];
                amt = ins[10:6];
                if (op2 != 2'd3) begin
                    if (amt == 0 && op2 != SH_LSL) amt = 32;
                    rd = {1'b0, ins[2:0]};
                    res = barrel(b, op2, amt, sc);
                    held_flags = '{n: res[31], z: (res == 0), c: sc, v: held_flags.v};
                    we = 1;
                end
            end
            CMD_ADDSUB3: begin
                v = ins[10] ? {29'd0, ins[8:6]} : b;
                rd = {1'b0, ins[2:0]};
                res = alu_eval(ins[9] ? ALU_SUB : ALU_ADD, a, v, held_flags.c, f);
                held_flags = f;
                we = 1;
            end
            CMD_IMM8: begin
                op2 = ins[12:11];
                rd = {1'b0, ins[10:8]};
                res = alu_eval(imm_map[op2], a, {24'd0, ins[7:0]}, held_flags.c, f);
                held_flags = f;
                we = (op2 != 2'd1);
            end
            CMD_ALU: begin
                op4 = ins[9:6];
                rd = {1'b0, ins[2:0]};
                if (op4 == 4'd13) begin
                    uns = 1; rd = '0;
                end else begin
                    if (op4 inside {4'd2, 4'd3, 4'd4, 4'd7}) begin
                        res = barrel(a, (op4 == 2) ? SH_LSL : (op4 == 3) ? SH_LSR :
                                        (op4 == 4) ? SH_ASR : SH_ROR, b[7:0], sc);
                        f = '{n: res[31], z: (res == 0), c: sc, v: held_flags.v};
                    end else if (op4 == 4'd9) begin
                        res = alu_eval(ALU_SUB, '0, b, held_flags.c, f);
                    end else begin
                        res = alu_eval(alu_map[op4], a, b, held_flags.c, f);
                    end
                    held_flags = f;
                    we = !(op4 == 8 || op4 == 10 || op4 == 11);
                end
            end
            CMD_HIREG: begin
                op2 = ins[9:8];
                if (op2 == 2'd3) begin
                    uns = 1;
                end else begin
                    rd = {ins[7], ins[2:0]};
                    if (op2 == 0) begin
                        res = a + b; we = 1;
                    end else if (op2 == 2) begin
                        res = b; we = 1;
                    end else begin
                        res = alu_eval(ALU_CMP, a, b, held_flags.c, f);
                        if (rd != REG_PC) held_flags = f;
                    end
                end
            end
            CMD_SPPC_ADD: begin
                v = ins[11] ? a : (a & ~32'd3);
                rd = {1'b0, ins[10:8]};
                res = v + {22'd0, ins[7:0], 2'b00};
                we = 1;
            end
            default: begin
                v = {23'd0, ins[6:0], 2'b00};
                rd = REG_SP;
                res = ins[7] ? (a - v) : (a + v);
                we = 1;
            end
        endcase
        o = '{result: res, dest: rd, we: we, rst: rst, n: held_flags.n, z: held_flags.z,
              c: held_flags.c, v: held_flags.v, uns: uns};
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_exec_result e, got;
        if (!i_rst_n) begin
            held_flags = '0;
            exec_results_q.delete();
            fail_count   = 0;
            result_count = 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_exec_result'(i_m_axis_tdata[42:0]);
                result_count++;
                if (exec_results_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    e = exec_results_q.pop_front();
                    check_field("result_value", e.result, got.result);
                    check_field("dest_reg", e.dest, got.dest);
                    check_field("write_enable", e.we, got.we);
                    check_field("restore_status", e.rst, got.rst);
                    check_field("neg_flag", e.n, got.n);
                    check_field("zero_flag", e.z, got.z);
                    check_field("carry_flag", e.c, got.c);
                    check_field("overflow_flag", e.v, got.v);
                    check_field("unsupported", e.uns, got.uns);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                exec_results_q.push_back(execute(i_s_axis_tdata));
        end
        pending = exec_results_q.size();
    end
endmodule

>>> verif/shifter_alu_with_flags_core_tb.sv
// ============================================================================
// shifter_alu_with_flags_core_tb
// stimulus and verdict for the execute stage
// ============================================================================
// drives directed instructions then random ones of every form over the slave
// stream, with random idling on both sides and one long result back-pressure
// stretch; a side checker predicts and compares every result transfer
module shifter_alu_with_flags_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import saf_pkg::*;

    localparam int RANDOM_ITEMS = 1500;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    int           fail_count;
    int           pending;
    int           result_count;
    int           sent_count;
    bit           calm;          // no idling in this stretch
    bit           hold_results;  // long receiver hold-off

    shifter_alu_with_flags_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    shifter_alu_with_flags_core_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // receiver: random stalls, unless calm or held off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_results && (calm || $urandom_range(99) >= 10);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(3))
            0: return {24'd0, 8'($urandom_range(31))};
            1: return {24'($urandom), 8'($urandom_range(30, 34))};
            default: return $urandom;
        endcase
    endfunction

    // one instruction transfer, with sender idling before it
    task automatic send_instr(input t_cmd cmd, input logic [31:0] ins, input logic [31:0] a,
                              input logic [31:0] b, input logic [31:0] rs);
        while (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, rs, b, a, ins, cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_random();
        t_cmd        cmd;
        logic [31:0] ins;
        cmd = t_cmd'($urandom_range(7));
        ins = $urandom;
        // wide forms: mostly real data-processing, some multiply and bx
        if (cmd == CMD_WIDE_DP) begin
            case ($urandom_range(9))
                0: ins = (ins & 32'hFDFF_FF0F) | 32'h0000_0090;
                1: ins = (ins & 32'hF000_002F) | 32'h012F_FF10;
                default: if (!ins[25] && ins[7:4] == 4'b1001) ins[7] = 1'b0;
            endcase
        end
        send_instr(cmd, ins, rand_word(), (cmd == CMD_ALU) ? rand_amount() : rand_word(),
                   rand_amount());
    endtask

    initial begin
        int cycles;
        t_alu_op op;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        calm         = 1'b0;
        hold_results = 1'b0;
        sent_count   = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every wide opcode with s set, register lsl, destination r1
        op = op.first();
        do begin
            send_instr(CMD_WIDE_DP, {4'hE, 3'b000, op, 1'b1, 4'd2, 4'd1, 8'd0, 4'd3},
                       32'hFFFF_FFFF, 32'h8000_0001, 32'd0);
            op = op.next();
        end while (op != op.first());
        // destination pc with s: no flag change, restore status
        send_instr(CMD_WIDE_DP, 32'hE29F_F001, 32'h7FFF_FFFF, 32'd0, 32'd0);
        // compare with s clear
        send_instr(CMD_WIDE_DP, 32'hE140_0002, 32'd5, 32'd5, 32'd0);
        // rrx, rotated immediate, register shift by 32 and 255
        send_instr(CMD_WIDE_DP, 32'hE1B0_0062, 32'd0, 32'h0000_0003, 32'd0);
        send_instr(CMD_WIDE_DP, 32'hE3B0_04FF, 32'd0, 32'd0, 32'd0);
        send_instr(CMD_WIDE_DP, 32'hE1B0_0312, 32'd0, 32'hFFFF_FFFF, 32'd32);
        send_instr(CMD_WIDE_DP, 32'hE1B0_0352, 32'd0, 32'h8000_0000, 32'hFF);
        // multiply and bx
        send_instr(CMD_WIDE_DP, 32'hE000_0091, 32'd1, 32'd1, 32'd1);
        send_instr(CMD_WIDE_DP, 32'hE12F_FF11, 32'd1, 32'd1, 32'd1);
        // compact shift no-op, mov immediate, mul, hireg cmp to pc, bx
        send_instr(CMD_SHIFT_IMM, 32'h0000_1800, 32'd1, 32'd1, 32'd0);
        send_instr(CMD_IMM8, 32'h0000_00FF, 32'd0, 32'd0, 32'd0);
        send_instr(CMD_ALU, 32'h0000_0340, 32'd3, 32'd3, 32'd0);
        send_instr(CMD_HIREG, 32'h0000_01FF, 32'd0, 32'd1, 32'd0);
        send_instr(CMD_HIREG, 32'h0000_0370, 32'd0, 32'd0, 32'd0);
        send_instr(CMD_SPPC_ADD, 32'h0000_00FF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_instr(CMD_SP_ADJ, 32'h0000_00FF, 32'd0, 32'd0, 32'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 600 && i < 800);
            if (i == 1000) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_results = 1'b1;
                        repeat (60) @(posedge i_clk);
                        hold_results = 1'b0;
                    end
                join_none
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        cycles = 0;
        while (pending != 0 && cycles < 10000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (4) @(posedge i_clk);
        $display("sent %0d instructions of all eight forms, checked %0d results",
                 sent_count, result_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS shifter_alu_with_flags_core");
        else
            $display("FAIL shifter_alu_with_flags_core");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL shifter_alu_with_flags_core");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/saf_pkg.sv
hw/rtl/saf_shifter.sv
hw/rtl/saf_exec.sv
hw/rtl/shifter_alu_with_flags_core.sv
verif/shifter_alu_with_flags_core_checker.sv
verif/shifter_alu_with_flags_core_tb.sv
